[rtl/core/twda_pkg.sv]
package twda_pkg;

   // field widths
   localparam int unsigned RAW_W    = 10;
   localparam int unsigned TENTHS_W = 12;
   localparam int unsigned SCALE_W  = 20;
   localparam int unsigned BAND_W   = 12;
   localparam int unsigned LEN_W    = 4;
   localparam int unsigned PHASE_W  = 4;
   localparam int unsigned SUM_W    = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 20;

   // product of raw sample and q16 scale, and the q16 fraction dropped
   localparam int unsigned PROD_W     = RAW_W + SCALE_W;
   localparam int unsigned FRAC_W     = 16;

   // exact divide of a SUM_W-bit sum by a depth of at most 32 via ceil reciprocal
   localparam int unsigned AVG_SHIFT  = SUM_W + 5;
   localparam int unsigned RECIP_W    = AVG_SHIFT;

   // reset values
   localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(211406);
   localparam logic [BAND_W-1:0]  BAND_RESET   = BAND_W'(20);
   localparam logic [LEN_W-1:0]   LENGTH_RESET = LEN_W'(4);

   localparam int unsigned WINDOW_DEPTH_DEFAULT = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SCALE  = 2'd0,
      REG_BAND   = 2'd1,
      REG_LENGTH = 2'd2
   } reg_index_type;

   // what the window row shows to the rest of the pipe
   typedef struct packed {
      logic [TENTHS_W-1:0] newest;
      logic [TENTHS_W-1:0] second;
      logic [TENTHS_W-1:0] third;
      logic [SUM_W-1:0]    sum;
   } taps_type;

endpackage

[rtl/core/twda_if.sv]
interface twda_req_if;
   logic                         valid;
   logic                         ready;
   logic [twda_pkg::RAW_W-1:0]   raw_sample;

   modport source (output valid, raw_sample, input ready);
   modport sink (input valid, raw_sample, output ready);
endinterface

interface twda_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [twda_pkg::TENTHS_W-1:0] newest_tenths;
   logic [twda_pkg::TENTHS_W-1:0] second_tenths;
   logic [twda_pkg::TENTHS_W-1:0] third_tenths;
   logic [twda_pkg::TENTHS_W-1:0] window_average;
   logic                          average_fresh;
   logic                          alarm_active;

   modport source (output valid, newest_tenths, second_tenths, third_tenths,
                   window_average, average_fresh, alarm_active, input ready);
   modport sink (input valid, newest_tenths, second_tenths, third_tenths,
                 window_average, average_fresh, alarm_active, output ready);
endinterface

interface twda_csr_if;
   logic                            valid;
   logic                            ready;
   logic [twda_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [twda_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

[rtl/core/temperature_window_deviation_alarm.sv]
// channel  dir  payload                                     handshake
// req      in   raw_sample                                  valid/ready
// rsp      out  newest/second/third_tenths, window_average,  valid/ready
//               average_fresh, alarm_active
// csr      in   reg_index, wdata                            valid/ready, always ready
//
// four-stage pipe: scale, window shift, average, band check; one beat per cycle while rsp is ready
// a req beat passes the scale, window, average and band-check registers on its way to rsp
// the alarm phase updates in the last stage only, so the feedback loop is a 4-bit count
// each stage moves when the stage after it is empty or moving, so bubbles collapse
// reset is synchronous; it clears the window, running sum, phase, held average
// and loads the register defaults
module temperature_window_deviation_alarm #(
   parameter int unsigned WINDOW_DEPTH = twda_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   twda_req_if.sink      req_bus,
   twda_rsp_if.source    rsp_bus,
   twda_csr_if.sink      csr_bus
);

   // ceil(2^AVG_SHIFT / depth) makes the shift-back exact for every 16-bit sum
   localparam int unsigned AvgRecip =
      ((1 << twda_pkg::AVG_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
   localparam int unsigned AvgProdW = twda_pkg::SUM_W + twda_pkg::RECIP_W;

   // ---------------- configuration registers ----------------
   logic [twda_pkg::SCALE_W-1:0] scale_ff;
   logic [twda_pkg::BAND_W-1:0]  band_ff;
   logic [twda_pkg::LEN_W-1:0]   length_ff;
   logic                         csr_write;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid & csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= twda_pkg::SCALE_RESET;
         band_ff   <= twda_pkg::BAND_RESET;
         length_ff <= twda_pkg::LENGTH_RESET;
      end else if (csr_write) begin
         unique case (csr_bus.reg_index)
            twda_pkg::REG_SCALE:  scale_ff  <= csr_bus.wdata;
            twda_pkg::REG_BAND:   band_ff   <= csr_bus.wdata[twda_pkg::BAND_W-1:0];
            twda_pkg::REG_LENGTH: length_ff <= csr_bus.wdata[twda_pkg::LEN_W-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // ---------------- stage enables ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4 = ~v4_ff | rsp_bus.ready;
   assign en3 = ~v3_ff | en4;
   assign en2 = ~v2_ff | en3;
   assign en1 = ~v1_ff | en2;

   assign req_bus.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: q16 scale and saturate ----------------
   logic [twda_pkg::PROD_W-1:0]          scale_prod;
   logic [twda_pkg::PROD_W-twda_pkg::FRAC_W-1:0] scale_int;
   logic [twda_pkg::TENTHS_W-1:0]        scaled_in, scaled_ff;

   assign scale_prod = twda_pkg::PROD_W'(req_bus.raw_sample) * twda_pkg::PROD_W'(scale_ff);
   assign scale_int  = scale_prod[twda_pkg::PROD_W-1:twda_pkg::FRAC_W];
   // anything above 4095 tenths pins at full scale
   assign scaled_in  = (|scale_int[twda_pkg::PROD_W-twda_pkg::FRAC_W-1:twda_pkg::TENTHS_W])
                     ? '1 : scale_int[twda_pkg::TENTHS_W-1:0];

   always_ff @(posedge clock) begin
      if (en1) scaled_ff <= scaled_in;
   end

   // ---------------- stage 2: window row and running sum ----------------
   twda_pkg::taps_type taps;

   twda_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (en2 & v1_ff),
      .sample   (scaled_ff),
      .taps     (taps)
   );

   // ---------------- stage 3: mean via reciprocal multiply ----------------
   logic [AvgProdW-1:0]           avg_prod;
   logic [twda_pkg::TENTHS_W-1:0] avg_in, avg3_ff;
   logic [twda_pkg::TENTHS_W-1:0] newest3_ff, second3_ff, third3_ff;

   assign avg_prod = AvgProdW'(taps.sum) * AvgProdW'(AvgRecip);
   assign avg_in   = avg_prod[twda_pkg::AVG_SHIFT +: twda_pkg::TENTHS_W];

   always_ff @(posedge clock) begin
      if (en3) begin
         avg3_ff    <= avg_in;
         newest3_ff <= taps.newest;
         second3_ff <= taps.second;
         third3_ff  <= taps.third;
      end
   end

   // ---------------- stage 4: band check and alarm phase ----------------
   logic                          take4;
   logic [twda_pkg::PHASE_W-1:0]  phase_ff, phase_in, phase_step;
   logic [twda_pkg::LEN_W-1:0]    len_eff;
   logic [twda_pkg::PHASE_W:0]    phase_inc;
   logic [twda_pkg::TENTHS_W-1:0] last_avg_ff, last_avg_in;
   logic [twda_pkg::TENTHS_W:0]   low_side, high_side;
   logic                          outside;
   logic                          fresh_in, active_in;
   logic [twda_pkg::TENTHS_W-1:0] newest_ff, second_ff, third_ff;
   logic                          fresh_ff, active_ff;

   assign take4 = en4 & v3_ff;

   // a zero length counts as one
   assign len_eff    = (length_ff == '0) ? twda_pkg::LEN_W'(1) : length_ff;
   assign phase_inc  = {1'b0, phase_ff} + 1'b1;
   assign phase_step = (phase_inc >= (twda_pkg::PHASE_W + 1)'(len_eff))
                     ? '0 : phase_inc[twda_pkg::PHASE_W-1:0];

   // newest < avg - band  <=>  newest + band < avg, so nothing wraps
   assign low_side  = {1'b0, newest3_ff} + {1'b0, band_ff};
   assign high_side = {1'b0, avg3_ff} + {1'b0, band_ff};
   assign outside   = (low_side < {1'b0, avg3_ff}) | ({1'b0, newest3_ff} > high_side);

   always_comb begin
      phase_in    = phase_ff;
      last_avg_in = last_avg_ff;
      fresh_in    = 1'b0;
      active_in   = 1'b0;
      if (phase_ff == '0) begin
         last_avg_in = avg3_ff;
         fresh_in    = 1'b1;
         if (outside) begin
            active_in = 1'b1;
            phase_in  = phase_step;
         end
      end else begin
         // mid-episode: no check, mean held
         active_in = 1'b1;
         phase_in  = phase_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         last_avg_ff <= '0;
      end else if (take4) begin
         phase_ff    <= phase_in;
         last_avg_ff <= last_avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take4) begin
         newest_ff <= newest3_ff;
         second_ff <= second3_ff;
         third_ff  <= third3_ff;
         fresh_ff  <= fresh_in;
         active_ff <= active_in;
      end
   end

   assign rsp_bus.valid          = v4_ff;
   assign rsp_bus.newest_tenths  = newest_ff;
   assign rsp_bus.second_tenths  = second_ff;
   assign rsp_bus.third_tenths   = third_ff;
   assign rsp_bus.window_average = last_avg_ff;
   assign rsp_bus.average_fresh  = fresh_ff;
   assign rsp_bus.alarm_active   = active_ff;

   // ---------------- checks ----------------
   // a held mean only ever shows up during an alarm
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.average_fresh |-> rsp_bus.alarm_active)
      else $error("stale average without alarm");

   // an accepted beat always lands in the scale stage
   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> v1_ff)
      else $error("accepted beat lost in stage one");

   // mid-episode beats never recompute the mean
   assert property (@(posedge clock) disable iff (reset)
      take4 && phase_ff != '0 |=> !rsp_bus.average_fresh && rsp_bus.alarm_active)
      else $error("check run during alarm episode");

   // the running sum stays the true window sum, which never exceeds depth * 4095
   assert property (@(posedge clock) disable iff (reset)
      taps.sum <= twda_pkg::SUM_W'(WINDOW_DEPTH * 4095))
      else $error("window sum out of range");

endmodule

[rtl/core/twda_cell.sv]
module twda_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic [twda_pkg::TENTHS_W-1:0] value_in,
   output logic [twda_pkg::TENTHS_W-1:0] value_out
);

   logic [twda_pkg::TENTHS_W-1:0] value_ff;
   logic [twda_pkg::TENTHS_W-1:0] value_next_in;

   // take the neighbor's value on a shift, otherwise hold
   assign value_next_in = shift_en ? value_in : value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_next_in;
      end
   end

   assign value_out = value_ff;

endmodule

[rtl/core/twda_window.sv]
module twda_window #(
   parameter int unsigned WINDOW_DEPTH = twda_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic [twda_pkg::TENTHS_W-1:0] sample,
   output twda_pkg::taps_type            taps
);

   logic [twda_pkg::TENTHS_W-1:0] cell_q [WINDOW_DEPTH];
   logic [twda_pkg::SUM_W-1:0]    sum_ff;
   logic [twda_pkg::SUM_W-1:0]    sum_in;

   // entry 0 is the oldest, the new sample enters at the far end
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      if (i == WINDOW_DEPTH - 1) begin : g_head
         twda_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .value_in  (sample),
            .value_out (cell_q[i])
         );
      end else begin : g_body
         twda_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .value_in  (cell_q[i+1]),
            .value_out (cell_q[i])
         );
      end
   end

   // running sum: the oldest drops out as the new one comes in
   assign sum_in = shift_en
                 ? sum_ff - twda_pkg::SUM_W'(cell_q[0]) + twda_pkg::SUM_W'(sample)
                 : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign taps.newest = cell_q[WINDOW_DEPTH-1];
   assign taps.second = cell_q[WINDOW_DEPTH-2];
   assign taps.sum    = sum_ff;

   if (WINDOW_DEPTH >= 3) begin : g_third
      assign taps.third = cell_q[WINDOW_DEPTH-3];
   end else begin : g_no_third
      assign taps.third = '0;
   end

endmodule

[test/twda_alarm_checker.sv]
module twda_alarm_checker #(
   parameter int unsigned WINDOW_DEPTH = twda_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   twda_req_if         req_mon,
   twda_rsp_if         rsp_mon,
   twda_csr_if         csr_mon,
   output int unsigned mismatches,
   output int unsigned outstanding,
   output int unsigned checked,
   output int unsigned alarmed
);
   import twda_pkg::*;

   typedef struct packed {
      logic [TENTHS_W-1:0] newest;
      logic [TENTHS_W-1:0] second;
      logic [TENTHS_W-1:0] third;
      logic [TENTHS_W-1:0] mean;
      logic                fresh;
      logic                alarm;
   } tenths_report_type;

   // shadow registers
   logic [SCALE_W-1:0]  scale_q16;
   logic [BAND_W-1:0]   band;
   logic [LEN_W-1:0]    episode_len;

   // shadow window state, entry WINDOW_DEPTH-1 is the newest
   logic [TENTHS_W-1:0] history [WINDOW_DEPTH];
   logic [SUM_W-1:0]    running_sum;
   logic [PHASE_W-1:0]  episode_step;
   logic [TENTHS_W-1:0] held_mean;

   tenths_report_type   expected_reports [$];
   int unsigned         bad = 0;
   int unsigned         seen = 0;
   int unsigned         alarms = 0;

   function automatic logic [PHASE_W-1:0] step_episode(input logic [PHASE_W-1:0] step);
      logic [LEN_W-1:0]   span;
      logic [PHASE_W:0]   nxt;
      // a zero length acts as one
      span = (episode_len == '0) ? LEN_W'(1) : episode_len;
      nxt  = step + 1'b1;
      if (nxt >= span) nxt = '0;
      return nxt[PHASE_W-1:0];
   endfunction

   task automatic predict_report(input logic [RAW_W-1:0] raw, output tenths_report_type rep);
      logic [PROD_W-1:0]        product;
      logic [PROD_W-FRAC_W-1:0] whole;
      logic [TENTHS_W-1:0]      scaled;
      logic [TENTHS_W-1:0]      oldest;
      int                       mean_lo;
      int                       mean_hi;
      int                       i;
      product = PROD_W'(raw) * PROD_W'(scale_q16);
      whole   = product[PROD_W-1:FRAC_W];
      scaled  = (whole > {TENTHS_W{1'b1}}) ? {TENTHS_W{1'b1}} : whole[TENTHS_W-1:0];
      oldest  = history[0];
      for (i = 0; i + 1 < WINDOW_DEPTH; i++) history[i] = history[i+1];
      history[WINDOW_DEPTH-1] = scaled;
      running_sum = running_sum - SUM_W'(oldest) + SUM_W'(scaled);
      rep.newest = history[WINDOW_DEPTH-1];
      rep.second = history[WINDOW_DEPTH-2];
      rep.third  = (WINDOW_DEPTH >= 3) ? history[(WINDOW_DEPTH >= 3) ? WINDOW_DEPTH-3 : 0] : '0;
      rep.fresh  = 1'b0;
      rep.alarm  = 1'b0;
      if (episode_step == '0) begin
         held_mean = TENTHS_W'(running_sum / WINDOW_DEPTH);
         rep.fresh = 1'b1;
         // signed bounds, the lower one may go negative
         mean_lo = int'(held_mean) - int'(band);
         mean_hi = int'(held_mean) + int'(band);
         if (int'(rep.newest) < mean_lo || int'(rep.newest) > mean_hi) begin
            rep.alarm    = 1'b1;
            episode_step = step_episode(episode_step);
         end
      end else begin
         rep.alarm    = 1'b1;
         episode_step = step_episode(episode_step);
      end
      rep.mean = held_mean;
   endtask

   function automatic int unsigned field_differs(input string label, input int unsigned want_v,
                                                 input int unsigned got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      tenths_report_type want;
      tenths_report_type got;
      if (reset) begin
         scale_q16   = SCALE_RESET;
         band        = BAND_RESET;
         episode_len = LENGTH_RESET;
         foreach (history[i]) history[i] = '0;
         running_sum  = '0;
         episode_step = '0;
         held_mean    = '0;
         expected_reports.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.reg_index)
               REG_SCALE:  scale_q16   = csr_mon.wdata[SCALE_W-1:0];
               REG_BAND:   band        = csr_mon.wdata[BAND_W-1:0];
               REG_LENGTH: episode_len = csr_mon.wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         // result side first so a beat never meets its own sample
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.newest = rsp_mon.newest_tenths;
            got.second = rsp_mon.second_tenths;
            got.third  = rsp_mon.third_tenths;
            got.mean   = rsp_mon.window_average;
            got.fresh  = rsp_mon.average_fresh;
            got.alarm  = rsp_mon.alarm_active;
            if (expected_reports.size() == 0) begin
               $display("%0t: result beat with no sample outstanding, expected none, actual %h",
                        $time, got);
               bad++;
            end else begin
               want = expected_reports.pop_front();
               bad += field_differs("newest_tenths", want.newest, got.newest);
               bad += field_differs("second_tenths", want.second, got.second);
               bad += field_differs("third_tenths", want.third, got.third);
               bad += field_differs("window_average", want.mean, got.mean);
               bad += field_differs("average_fresh", want.fresh, got.fresh);
               bad += field_differs("alarm_active", want.alarm, got.alarm);
               seen++;
               if (got.alarm) alarms++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_report(req_mon.raw_sample, want);
            expected_reports.push_back(want);
         end
      end
      mismatches  <= bad;
      outstanding <= expected_reports.size();
      checked     <= seen;
      alarmed     <= alarms;
   end

endmodule

[test/tb_temperature_window_deviation_alarm.sv]
module tb_temperature_window_deviation_alarm;
   import twda_pkg::*;

   localparam int unsigned DEPTH         = WINDOW_DEPTH_DEFAULT;
   // cycles with no beat anywhere before the run is declared hung
   localparam int unsigned STALL_LIMIT   = 2000;
   // margin after the last result, well past the four-stage pipe
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_ITEMS   = 150;
   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   logic        clock;
   logic        reset;

   twda_req_if  req_bus ();
   twda_rsp_if  rsp_bus ();
   twda_csr_if  csr_bus ();

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned checked;
   int unsigned alarmed;

   // no idling on either side while set
   bit          steady = 1'b0;
   int unsigned sent = 0;
   int unsigned settings = 0;
   int unsigned quiet_cycles = 0;

   temperature_window_deviation_alarm #(
      .WINDOW_DEPTH (DEPTH)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // watches all three channels and predicts every result beat
   twda_alarm_checker #(
      .WINDOW_DEPTH (DEPTH)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked),
      .alarmed     (alarmed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side back-pressure, about one stalled cycle in five
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 20);
      end
   end

   // hang detection: any accepted beat restarts the count
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, outstanding);
         $display("tb_temperature_window_deviation_alarm failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one sample beat; valid stays high into the next sample unless a gap is drawn
   task automatic send_sample(input logic [RAW_W-1:0] raw);
      int unsigned gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(0, 99) < 20) gap++;
      end
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.raw_sample <= raw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   // stop sending and wait until every predicted result has come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wdata     <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // all three registers; bits above each field carry junk that must be dropped
   task automatic apply_setting(input logic [SCALE_W-1:0] scale, input logic [BAND_W-1:0] band,
                                input logic [LEN_W-1:0] span);
      logic [CSR_DATA_W-1:0] junk;
      write_reg(REG_SCALE, CSR_DATA_W'(scale));
      junk = CSR_DATA_W'($urandom);
      junk[BAND_W-1:0] = band;
      write_reg(REG_BAND, junk);
      junk = CSR_DATA_W'($urandom);
      junk[LEN_W-1:0] = span;
      write_reg(REG_LENGTH, junk);
      settings++;
   endtask

   initial begin
      int                 level;
      int                 raw_val;
      int                 delta;
      int unsigned        pick;
      int unsigned        ph;
      int unsigned        n;
      logic [SCALE_W-1:0] scale;
      logic [BAND_W-1:0]  band;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.raw_sample <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.reg_index  <= REG_SCALE;
      csr_bus.wdata      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----

      // reset registers: quiet start, full-scale jump opens an alarm of four,
      // the held mean shows while it runs, then a fresh check follows
      send_sample('0);
      send_sample('0);
      send_sample('1);
      send_sample('0);
      send_sample('0);
      send_sample('0);
      send_sample('0);
      settle();

      // largest scale saturates, zero band, one-sample alarms
      apply_setting('1, '0, LEN_W'(1));
      send_sample('1);
      send_sample(10'h2aa);
      send_sample(10'h155);
      send_sample(10'd255);
      send_sample(10'd256);
      settle();

      // unity scale with zero alarm length: alarm only on the trigger sample
      apply_setting(SCALE_W'(65536), '0, '0);
      send_sample(10'd100);
      send_sample(10'd100);
      send_sample(10'd700);
      settle();

      // long episode, then shorten it while it runs so it ends at the next sample
      write_reg(REG_LENGTH, CSR_DATA_W'(15));
      send_sample('1);
      send_sample('1);
      send_sample('1);
      settle();
      write_reg(REG_LENGTH, CSR_DATA_W'(2));
      send_sample('0);
      send_sample('0);
      settle();

      // zero scale and widest band; the spare index must change nothing
      apply_setting('0, '1, LEN_W'(15));
      write_reg(REG_SPARE, CSR_DATA_W'($urandom));
      send_sample('1);
      send_sample('0);
      settle();

      // ---- random part ----
      // mostly a slow temperature drift with spikes and step changes,
      // plus a share of fully random readings
      level = 300;
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: apply_setting(SCALE_RESET, BAND_RESET, LENGTH_RESET);
            1: apply_setting('1, '0, LEN_W'(15));
            2: apply_setting('0, '1, LEN_W'(1));
            default: begin
               scale = ($urandom_range(0, 99) < 70) ? SCALE_W'($urandom_range(100000, 300000))
                                                    : SCALE_W'($urandom);
               band  = ($urandom_range(0, 99) < 70) ? BAND_W'($urandom_range(0, 60))
                                                    : BAND_W'($urandom);
               apply_setting(scale, band, LEN_W'($urandom_range(0, 15)));
            end
         endcase
         // one whole phase runs with no idling on either side
         steady = (ph == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off mid-phase until the pipe has emptied
            if (ph == 5 && n == PHASE_ITEMS / 2) settle();
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               raw_val = $urandom_range(0, 1023);
            end else if (pick < 18) begin
               // single-sample spike around the current level
               delta = int'($urandom_range(60, 400));
               if ($urandom_range(0, 1) != 0) delta = -delta;
               raw_val = level + delta;
            end else begin
               if (pick < 20) level = int'($urandom_range(0, 1023));
               level = level + int'($urandom_range(0, 8)) - 4;
               if (level < 0) level = 0;
               if (level > 1023) level = 1023;
               raw_val = level;
            end
            if (raw_val < 0) raw_val = 0;
            if (raw_val > 1023) raw_val = 1023;
            send_sample(raw_val[RAW_W-1:0]);
         end
         settle();
      end
      steady = 1'b0;

      $display("run covered %0d samples over %0d register settings, %0d results checked",
               sent, settings, checked);
      $display("%0d of those results were sounding an alarm", alarmed);
      if (mismatches == 0) begin
         $display("tb_temperature_window_deviation_alarm passed");
      end else begin
         $display("tb_temperature_window_deviation_alarm failed");
      end
      $finish;
   end

endmodule

[temperature_window_deviation_alarm.f]
rtl/core/twda_pkg.sv
rtl/core/twda_if.sv
rtl/core/twda_cell.sv
rtl/core/twda_window.sv
rtl/core/temperature_window_deviation_alarm.sv
test/twda_alarm_checker.sv
test/tb_temperature_window_deviation_alarm.sv
